### src/dismiss_retry_tracker_top_assert.svh
// Assertion macros for the dismiss retry tracker.
// Used by dismiss_retry_tracker_top; no other dependencies.
`ifndef DISMISS_RETRY_TRACKER_TOP_ASSERT_SVH
`define DISMISS_RETRY_TRACKER_TOP_ASSERT_SVH
`ifndef SYNTH
`define DRT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("drt assertion failed");
`define DRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("drt assertion failed");
`else
`define DRT_ASSERT_SAME(label, clk, rst, ante, cons)
`define DRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/drt_pkg.sv
// Shared types, constants and helpers for the dismiss retry tracker.
// No dependencies.
package drt_pkg;

   localparam int ENTRIES_DEF = 16;
   localparam int TAG_W       = 32;
   localparam int REV_W       = 48;
   localparam int TIME_W      = 48;
   localparam int SEND_W      = 4;
   localparam int CSR_W       = 48;
   localparam int CSR_IDX_W   = 2;
   localparam int MAX_RESULTS = 16;
   localparam int KW          = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {
      OP_DISMISS = 2'd0,
      OP_SERVICE = 2'd1,
      OP_ACK     = 2'd2,
      OP_FILTER  = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SENDS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REV     = 2'd2;

   localparam logic [TIME_W-1:0] RST_ACK_TIMEOUT = 48'd5000000;
   localparam logic [SEND_W-1:0] RST_MAX_SENDS   = 4'd3;
   localparam logic [REV_W-1:0]  RST_MAX_REV     = {REV_W{1'b1}};

   typedef struct packed {
      logic [TIME_W-1:0] ack_timeout_us;
      logic [SEND_W-1:0] max_sends;
      logic [REV_W-1:0]  max_revision;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic [TAG_W-1:0]  timer_tag;
      logic [REV_W-1:0]  revision;
      logic              timer_expired;
      logic [TIME_W-1:0] due_ms;
      logic [TIME_W-1:0] time_now;
      logic [TAG_W-1:0]  request_tag;
      logic              negotiated;
      logic [TAG_W-1:0]  session_tag;
      logic [TAG_W-1:0]  other_session_tag;
      logic              message_ok;
      logic              last_timer;
   } item_type;

   typedef struct packed {
      logic [1:0]       result_kind;
      logic             flag;
      logic             frame_valid;
      logic [TAG_W-1:0] frame_timer_tag;
      logic [REV_W-1:0] frame_revision;
      logic [TAG_W-1:0] frame_request_tag;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0]  timer;
      logic [REV_W-1:0]  rev;
      logic [TAG_W-1:0]  req;
      logic [SEND_W-1:0] sends;
      logic [TIME_W-1:0] last_send;
   } pend_ent_type;

   typedef struct packed {
      logic [TAG_W-1:0] timer;
      logic [REV_W-1:0] rev;
      logic             seen;
   } supp_ent_type;

   typedef struct packed {
      logic busy;
      logic push;
   } stat_type;

   function automatic rsp_type mk_rsp(logic [1:0] kind, logic flag);
      rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.flag = flag;
      r.last = 1'b1;
      return r;
   endfunction

endpackage

### src/drt_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module drt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### src/drt_seq.sv
// Sequencer for the tracker: scans and compacts the pending and suppression RAMs.
// Depends on drt_pkg and drt_ram.
module drt_seq import drt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  item_type item,
   input  cfg_type  cfg,
   input  logic     out_free,
   output stat_type stat,
   output rsp_type  push_rsp
);

   localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNTW = $clog2(ENTRIES + 1);
   localparam logic [CNTW-1:0] FULL = CNTW'(ENTRIES);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD   = 5'b00010,
      S_PROC = 5'b00100,
      S_WR   = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   typedef enum logic [8:0] {
      PH_PSRCH  = 9'b000000001,
      PH_PEVICT = 9'b000000010,
      PH_PAPND  = 9'b000000100,
      PH_SUPD   = 9'b000001000,
      PH_SEVICT = 9'b000010000,
      PH_SAPND  = 9'b000100000,
      PH_SVC    = 9'b001000000,
      PH_ACK    = 9'b010000000,
      PH_FILT   = 9'b100000000
   } phase_type;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   item_type      item_ff, item_in;
   logic [CNTW-1:0] r_ff, r_in, w_ff, w_in, np_ff, np_in, pn_ff, pn_in, sn_ff, sn_in;
   logic          hit_ff, hit_in, keep_ff, keep_in, hold_v_ff, hold_v_in;
   logic [KW-1:0] k_ff, k_in;
   rsp_type       hold_ff, hold_in, fin_ff, fin_in;

   logic          p_we, p_re, s_we, s_re, push;
   logic [IDXW-1:0] p_waddr, s_waddr, rd_addr;
   pend_ent_type  p_wdata, pd;
   supp_ent_type  s_wdata, sd;

   logic          d_gate, a_gate, due, at_limit, link, fv, rec;
   logic          f_match, f_gt, f_seen;
   logic [TIME_W-1:0] elapsed;
   rsp_type       svc_rsp;
   logic          keep_ent;

   drt_ram #(.WIDTH($bits(pend_ent_type)), .DEPTH(ENTRIES), .AW(IDXW)) u_pend_ram (
      .clock(clock), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
      .re(p_re), .raddr(rd_addr), .rdata(pd)
   );

   drt_ram #(.WIDTH($bits(supp_ent_type)), .DEPTH(ENTRIES), .AW(IDXW)) u_supp_ram (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .re(s_re), .raddr(rd_addr), .rdata(sd)
   );

   assign rd_addr = r_ff[IDXW-1:0];

   assign d_gate = item.negotiated && (item.session_tag != '0)
                   && (item.other_session_tag == item.session_tag)
                   && (item.timer_expired
                       || ((item.time_now != '0) && (item.due_ms <= item.time_now)))
                   && (item.timer_tag != '0) && (item.revision != '0);
   assign a_gate = item.message_ok && (item.session_tag != '0)
                   && (item.session_tag == item.other_session_tag);

   assign elapsed  = item_ff.time_now - pd.last_send;
   assign due      = (pd.sends == '0)
                     || ((item_ff.time_now >= pd.last_send) && (elapsed >= cfg.ack_timeout_us));
   assign at_limit = pd.sends >= cfg.max_sends;
   assign link     = item_ff.negotiated && (item_ff.session_tag != '0);
   assign fv       = (pd.rev != '0) && (pd.rev <= cfg.max_revision);
   assign rec      = k_ff < KW'(MAX_RESULTS);

   always_comb begin
      svc_rsp = '0;
      svc_rsp.result_kind       = OP_SERVICE;
      svc_rsp.frame_valid       = fv;
      svc_rsp.frame_timer_tag   = pd.timer;
      svc_rsp.frame_revision    = pd.rev;
      svc_rsp.frame_request_tag = pd.req;
   end

   assign f_match = !hit_ff && (sd.timer == item_ff.timer_tag) && !sd.seen;
   assign f_gt    = item_ff.revision > sd.rev;
   assign f_seen  = sd.seen | (f_match & !f_gt);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      item_in   = item_ff;
      r_in      = r_ff;
      w_in      = w_ff;
      np_in     = np_ff;
      pn_in     = pn_ff;
      sn_in     = sn_ff;
      hit_in    = hit_ff;
      keep_in   = keep_ff;
      hold_v_in = hold_v_ff;
      k_in      = k_ff;
      hold_in   = hold_ff;
      fin_in    = fin_ff;
      p_we      = 1'b0;
      s_we      = 1'b0;
      p_re      = 1'b0;
      s_re      = 1'b0;
      p_waddr   = w_ff[IDXW-1:0];
      s_waddr   = w_ff[IDXW-1:0];
      p_wdata   = pd;
      s_wdata   = sd;
      push      = 1'b0;
      push_rsp  = fin_ff;
      keep_ent  = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in   = item;
               r_in      = '0;
               w_in      = '0;
               hit_in    = 1'b0;
               keep_in   = 1'b1;
               hold_v_in = 1'b0;
               k_in      = '0;
               unique case (item.op)
                  OP_DISMISS: begin
                     if (d_gate) begin
                        phase_in = PH_PSRCH;
                        np_in    = pn_ff;
                        state_in = S_RD;
                     end else begin
                        fin_in   = mk_rsp(OP_DISMISS, 1'b0);
                        state_in = S_DONE;
                     end
                  end
                  OP_SERVICE: begin
                     phase_in = PH_SVC;
                     np_in    = pn_ff;
                     state_in = S_RD;
                  end
                  OP_ACK: begin
                     if (a_gate) begin
                        phase_in = PH_ACK;
                        np_in    = pn_ff;
                        state_in = S_RD;
                     end else begin
                        fin_in   = mk_rsp(OP_ACK, 1'b0);
                        state_in = S_DONE;
                     end
                  end
                  OP_FILTER: begin
                     if (item.other_session_tag != '0) begin
                        phase_in = PH_FILT;
                        np_in    = sn_ff;
                        state_in = S_RD;
                     end else begin
                        fin_in   = mk_rsp(OP_FILTER, 1'b1);
                        state_in = S_DONE;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_RD: begin
            if (r_ff == np_ff) begin
               // end of pass: commit the compacted count, pick the next step
               r_in = '0;
               w_in = '0;
               if ((phase_ff == PH_PSRCH) || (phase_ff == PH_PEVICT)
                   || (phase_ff == PH_SVC) || (phase_ff == PH_ACK)) begin
                  pn_in = w_ff;
               end else begin
                  sn_in = w_ff;
               end
               unique case (phase_ff)
                  PH_PSRCH: begin
                     if (hit_ff) begin
                        phase_in = PH_SUPD;
                        np_in    = sn_ff;
                        hit_in   = 1'b0;
                     end else if (item_ff.request_tag == '0) begin
                        fin_in   = mk_rsp(OP_DISMISS, 1'b0);
                        state_in = S_DONE;
                     end else if (w_ff == FULL) begin
                        phase_in = PH_PEVICT;
                        np_in    = w_ff;
                     end else begin
                        phase_in = PH_PAPND;
                        state_in = S_WR;
                     end
                  end
                  PH_PEVICT: begin
                     phase_in = PH_PAPND;
                     state_in = S_WR;
                  end
                  PH_SUPD: begin
                     if (hit_ff) begin
                        fin_in   = mk_rsp(OP_DISMISS, 1'b1);
                        state_in = S_DONE;
                     end else if (w_ff == FULL) begin
                        phase_in = PH_SEVICT;
                        np_in    = w_ff;
                     end else begin
                        phase_in = PH_SAPND;
                        state_in = S_WR;
                     end
                  end
                  PH_SEVICT: begin
                     phase_in = PH_SAPND;
                     state_in = S_WR;
                  end
                  PH_SVC: begin
                     if (hold_v_ff) begin
                        fin_in      = hold_ff;
                        fin_in.last = 1'b1;
                     end else begin
                        fin_in = mk_rsp(OP_SERVICE, 1'b0);
                     end
                     hold_v_in = 1'b0;
                     state_in  = S_DONE;
                  end
                  PH_ACK: begin
                     fin_in   = mk_rsp(OP_ACK, 1'b1);
                     state_in = S_DONE;
                  end
                  PH_FILT: begin
                     fin_in   = mk_rsp(OP_FILTER, keep_ff);
                     state_in = S_DONE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end else begin
               if ((phase_ff == PH_PSRCH) || (phase_ff == PH_PEVICT)
                   || (phase_ff == PH_SVC) || (phase_ff == PH_ACK)) begin
                  p_re = 1'b1;
               end else begin
                  s_re = 1'b1;
               end
               state_in = S_PROC;
            end
         end

         S_PROC: begin
            state_in = S_RD;
            unique case (phase_ff)
               PH_PSRCH: begin
                  if ((pd.timer == item_ff.timer_tag) && (pd.rev == item_ff.revision)) begin
                     hit_in = 1'b1;
                  end
                  p_we = 1'b1;
               end
               PH_PEVICT: begin
                  keep_ent = r_ff != '0;
                  p_we     = keep_ent;
               end
               PH_ACK: begin
                  keep_ent = !((pd.timer == item_ff.timer_tag)
                               && (pd.req == item_ff.request_tag));
                  p_we     = keep_ent;
               end
               PH_SVC: begin
                  priority if (!due) begin
                     p_we = 1'b1;
                  end else if (at_limit) begin
                     keep_ent = 1'b0;
                  end else if (link) begin
                     if (rec && hold_v_ff && !out_free) begin
                        state_in = S_PROC;
                     end else begin
                        if (rec) begin
                           push      = hold_v_ff;
                           push_rsp  = hold_ff;
                           hold_in   = svc_rsp;
                           hold_v_in = 1'b1;
                           k_in      = k_ff + KW'(1);
                        end
                        p_wdata.sends     = pd.sends + SEND_W'(1);
                        p_wdata.last_send = item_ff.time_now;
                        p_we              = 1'b1;
                     end
                  end else begin
                     p_we = 1'b1;
                  end
               end
               PH_SUPD: begin
                  if (!hit_ff && (sd.timer == item_ff.timer_tag)) begin
                     hit_in = 1'b1;
                     if (item_ff.revision > sd.rev) begin
                        s_wdata.rev = item_ff.revision;
                     end
                  end
                  s_we = 1'b1;
               end
               PH_SEVICT: begin
                  keep_ent = r_ff != '0;
                  s_we     = keep_ent;
               end
               PH_FILT: begin
                  if (f_match) begin
                     hit_in = 1'b1;
                     if (!f_gt) begin
                        keep_in = 1'b0;
                     end
                  end
                  keep_ent     = !(f_match && f_gt) && (!item_ff.last_timer || f_seen);
                  s_wdata.seen = item_ff.last_timer ? 1'b0 : f_seen;
                  s_we         = keep_ent;
               end
               default: state_in = S_IDLE;
            endcase
            if (state_in == S_RD) begin
               r_in = r_ff + CNTW'(1);
               w_in = w_ff + CNTW'(keep_ent);
            end
         end

         S_WR: begin
            if (phase_ff == PH_PAPND) begin
               p_we            = 1'b1;
               p_waddr         = pn_ff[IDXW-1:0];
               p_wdata         = '0;
               p_wdata.timer   = item_ff.timer_tag;
               p_wdata.rev     = item_ff.revision;
               p_wdata.req     = item_ff.request_tag;
               pn_in           = pn_ff + CNTW'(1);
               phase_in        = PH_SUPD;
               np_in           = sn_ff;
               hit_in          = 1'b0;
               r_in            = '0;
               w_in            = '0;
               state_in        = S_RD;
            end else begin
               s_we          = 1'b1;
               s_waddr       = sn_ff[IDXW-1:0];
               s_wdata.timer = item_ff.timer_tag;
               s_wdata.rev   = item_ff.revision;
               s_wdata.seen  = 1'b0;
               sn_in         = sn_ff + CNTW'(1);
               fin_in        = mk_rsp(OP_DISMISS, 1'b1);
               state_in      = S_DONE;
            end
         end

         S_DONE: begin
            if (out_free) begin
               push     = 1'b1;
               push_rsp = fin_ff;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_PSRCH;
         pn_ff     <= '0;
         sn_ff     <= '0;
         hold_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         pn_ff     <= pn_in;
         sn_ff     <= sn_in;
         hold_v_ff <= hold_v_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      r_ff    <= r_in;
      w_ff    <= w_in;
      np_ff   <= np_in;
      hit_ff  <= hit_in;
      keep_ff <= keep_in;
      k_ff    <= k_in;
      hold_ff <= hold_in;
      fin_ff  <= fin_in;
   end

   assign stat.busy = state_ff != S_IDLE;
   assign stat.push = push;

endmodule

### src/dismiss_retry_tracker_top.sv
// Top level of the dismiss retry tracker: ports, registers, result register.
// Depends on drt_pkg, drt_seq and the assertion macro header.
//
//   channel  direction  handshake           payload
//   req_     in         req_valid/req_stall  one item, one port per field
//   rsp_     out        rsp_valid/rsp_stall  one result, one port per field
//   csr_     in         csr_we               csr_index, csr_wdata
//
// Items are taken one at a time. A scan reads each table entry from RAM, then updates and
// writes it back; dismiss runs up to four scans plus appends, and service, ack and filter
// run at most one scan each.
// Synchronous reset empties both tables at once through their fill counts.
// A stalled result holds the sequencer in its final cycle, and mid-scan when a further
// service result must be stored.
module dismiss_retry_tracker_top import drt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [TAG_W-1:0]     req_timer_tag,
   input  logic [REV_W-1:0]     req_revision,
   input  logic                 req_timer_expired,
   input  logic [TIME_W-1:0]    req_due_ms,
   input  logic [TIME_W-1:0]    req_time_now,
   input  logic [TAG_W-1:0]     req_request_tag,
   input  logic                 req_negotiated,
   input  logic [TAG_W-1:0]     req_session_tag,
   input  logic [TAG_W-1:0]     req_other_session_tag,
   input  logic                 req_message_ok,
   input  logic                 req_last_timer,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_result_kind,
   output logic                 rsp_flag,
   output logic                 rsp_frame_valid,
   output logic [TAG_W-1:0]     rsp_frame_timer_tag,
   output logic [REV_W-1:0]     rsp_frame_revision,
   output logic [TAG_W-1:0]     rsp_frame_request_tag,
   output logic                 rsp_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

`include "dismiss_retry_tracker_top_assert.svh"

   cfg_type  cfg_ff, cfg_in;
   item_type item;
   stat_type stat;
   rsp_type  push_rsp, rsp_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     accept, out_free;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ACK_TIMEOUT: cfg_in.ack_timeout_us = csr_wdata[TIME_W-1:0];
            CSR_MAX_SENDS:   cfg_in.max_sends      = csr_wdata[SEND_W-1:0];
            CSR_MAX_REV:     cfg_in.max_revision   = csr_wdata[REV_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      item.op                = op_type'(req_opcode);
      item.timer_tag         = req_timer_tag;
      item.revision          = req_revision;
      item.timer_expired     = req_timer_expired;
      item.due_ms            = req_due_ms;
      item.time_now          = req_time_now;
      item.request_tag       = req_request_tag;
      item.negotiated        = req_negotiated;
      item.session_tag       = req_session_tag;
      item.other_session_tag = req_other_session_tag;
      item.message_ok        = req_message_ok;
      item.last_timer        = req_last_timer;
   end

   assign req_stall = stat.busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   drt_seq #(.ENTRIES(ENTRIES)) u_seq (
      .clock(clock), .reset(reset), .start(accept), .item(item), .cfg(cfg_ff),
      .out_free(out_free), .stat(stat), .push_rsp(push_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stat.push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_timeout_us <= RST_ACK_TIMEOUT;
         cfg_ff.max_sends      <= RST_MAX_SENDS;
         cfg_ff.max_revision   <= RST_MAX_REV;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.push) begin
         rsp_ff <= push_rsp;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result_kind       = rsp_ff.result_kind;
   assign rsp_flag              = rsp_ff.flag;
   assign rsp_frame_valid       = rsp_ff.frame_valid;
   assign rsp_frame_timer_tag   = rsp_ff.frame_timer_tag;
   assign rsp_frame_revision    = rsp_ff.frame_revision;
   assign rsp_frame_request_tag = rsp_ff.frame_request_tag;
   assign rsp_last              = rsp_ff.last;

   `DRT_ASSERT_NEXT(a_accept_busy, clock, reset, accept, stat.busy)
   `DRT_ASSERT_SAME(a_push_room, clock, reset, stat.push, out_free)
   `DRT_ASSERT_NEXT(a_push_shown, clock, reset, stat.push, rsp_valid_ff)

endmodule

### dv/dismiss_retry_tracker_checker.sv
// Checker for the dismiss retry tracker: watches the request, result and register ports.
// Predicts the results of every request transfer and compares them field by field.
// Depends on drt_pkg.
`timescale 1ns / 1ps
module dismiss_retry_tracker_checker import drt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_opcode,
   input  logic [TAG_W-1:0]     req_timer_tag,
   input  logic [REV_W-1:0]     req_revision,
   input  logic                 req_timer_expired,
   input  logic [TIME_W-1:0]    req_due_ms,
   input  logic [TIME_W-1:0]    req_time_now,
   input  logic [TAG_W-1:0]     req_request_tag,
   input  logic                 req_negotiated,
   input  logic [TAG_W-1:0]     req_session_tag,
   input  logic [TAG_W-1:0]     req_other_session_tag,
   input  logic                 req_message_ok,
   input  logic                 req_last_timer,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_result_kind,
   input  logic                 rsp_flag,
   input  logic                 rsp_frame_valid,
   input  logic [TAG_W-1:0]     rsp_frame_timer_tag,
   input  logic [REV_W-1:0]     rsp_frame_revision,
   input  logic [TAG_W-1:0]     rsp_frame_request_tag,
   input  logic                 rsp_last,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output int                   err_count,
   output int                   owed_count
);

   pend_ent_type pend[ENTRIES_DEF];
   supp_ent_type supp[ENTRIES_DEF];
   int pend_n, supp_n;
   cfg_type cfg;
   rsp_type owed_rsp[$];

   initial begin
      err_count = 0;
      owed_count = 0;
   end

   task automatic flag_mismatch(string what);
      $display("checker: %s at %0t", what, $time);
      err_count++;
   endtask

   task automatic drop_pend(int i);
      for (int j = i; j < pend_n - 1; j++) pend[j] = pend[j + 1];
      pend_n--;
   endtask

   task automatic drop_supp(int i);
      for (int j = i; j < supp_n - 1; j++) supp[j] = supp[j + 1];
      supp_n--;
   endtask

   function automatic rsp_type plain_rsp(logic [1:0] kind, logic flag);
      rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.flag = flag;
      r.last = 1'b1;
      return r;
   endfunction

   task automatic track_item(item_type it);
      logic due, already, ok, found, keep, flag;
      rsp_type r;
      rsp_type batch[$];
      int i;
      case (it.op)
         OP_DISMISS: begin
            flag = 1'b0;
            due = it.timer_expired || (it.time_now != 0 && it.due_ms <= it.time_now);
            if (it.negotiated && it.session_tag != 0 && it.other_session_tag == it.session_tag
                && due && it.timer_tag != 0 && it.revision != 0) begin
               already = 1'b0;
               ok = 1'b1;
               for (i = 0; i < pend_n; i++)
                  if (pend[i].timer == it.timer_tag && pend[i].rev == it.revision)
                     already = 1'b1;
               if (!already) begin
                  if (it.request_tag == 0) begin
                     ok = 1'b0;
                  end else begin
                     if (pend_n >= ENTRIES_DEF) drop_pend(0);
                     pend[pend_n] = '{it.timer_tag, it.revision, it.request_tag, '0, '0};
                     pend_n++;
                  end
               end
               if (ok) begin
                  found = 1'b0;
                  for (i = 0; i < supp_n && !found; i++) begin
                     if (supp[i].timer == it.timer_tag) begin
                        if (it.revision > supp[i].rev) supp[i].rev = it.revision;
                        found = 1'b1;
                     end
                  end
                  if (!found) begin
                     if (supp_n >= ENTRIES_DEF) drop_supp(0);
                     supp[supp_n] = '{it.timer_tag, it.revision, 1'b0};
                     supp_n++;
                  end
                  flag = 1'b1;
               end
            end
            owed_rsp = {owed_rsp, plain_rsp(OP_DISMISS, flag)};
         end
         OP_SERVICE: begin
            i = 0;
            while (i < pend_n) begin
               due = pend[i].sends == 0 || (it.time_now >= pend[i].last_send &&
                     it.time_now - pend[i].last_send >= cfg.ack_timeout_us);
               if (!due) begin
                  i++;
               end else if (pend[i].sends >= cfg.max_sends) begin
                  drop_pend(i);
               end else begin
                  if (it.negotiated && it.session_tag != 0) begin
                     if (batch.size() < MAX_RESULTS) begin
                        r = plain_rsp(OP_SERVICE, 1'b0);
                        r.last = 1'b0;
                        r.frame_valid = pend[i].rev != 0 && pend[i].rev <= cfg.max_revision;
                        r.frame_timer_tag = pend[i].timer;
                        r.frame_revision = pend[i].rev;
                        r.frame_request_tag = pend[i].req;
                        batch = {batch, r};
                     end
                     pend[i].sends = pend[i].sends + 1'b1;
                     pend[i].last_send = it.time_now;
                  end
                  i++;
               end
            end
            if (batch.size() == 0) batch = {batch, plain_rsp(OP_SERVICE, 1'b0)};
            batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k]) owed_rsp = {owed_rsp, batch[k]};
         end
         OP_ACK: begin
            flag = 1'b0;
            if (it.message_ok && it.session_tag != 0 && it.session_tag == it.other_session_tag)
            begin
               i = 0;
               while (i < pend_n) begin
                  if (pend[i].timer == it.timer_tag && pend[i].req == it.request_tag) drop_pend(i);
                  else i++;
               end
               flag = 1'b1;
            end
            owed_rsp = {owed_rsp, plain_rsp(OP_ACK, flag)};
         end
         default: begin
            keep = 1'b1;
            if (it.other_session_tag != 0) begin
               found = 1'b0;
               for (i = 0; i < supp_n && !found; i++) begin
                  if (supp[i].timer == it.timer_tag && !supp[i].seen) begin
                     found = 1'b1;
                     if (it.revision > supp[i].rev) begin
                        drop_supp(i);
                     end else begin
                        supp[i].seen = 1'b1;
                        keep = 1'b0;
                     end
                  end
               end
               if (it.last_timer) begin
                  i = 0;
                  while (i < supp_n) begin
                     if (!supp[i].seen) drop_supp(i);
                     else begin
                        supp[i].seen = 1'b0;
                        i++;
                     end
                  end
               end
            end
            owed_rsp = {owed_rsp, plain_rsp(OP_FILTER, keep)};
         end
      endcase
   endtask

   always @(posedge clock) begin
      item_type it;
      rsp_type want;
      if (reset) begin
         pend_n = 0;
         supp_n = 0;
         cfg.ack_timeout_us = RST_ACK_TIMEOUT;
         cfg.max_sends = RST_MAX_SENDS;
         cfg.max_revision = RST_MAX_REV;
         owed_rsp.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ACK_TIMEOUT: cfg.ack_timeout_us = csr_wdata[TIME_W-1:0];
               CSR_MAX_SENDS:   cfg.max_sends = csr_wdata[SEND_W-1:0];
               CSR_MAX_REV:     cfg.max_revision = csr_wdata[REV_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            it.op = op_type'(req_opcode);
            it.timer_tag = req_timer_tag;
            it.revision = req_revision;
            it.timer_expired = req_timer_expired;
            it.due_ms = req_due_ms;
            it.time_now = req_time_now;
            it.request_tag = req_request_tag;
            it.negotiated = req_negotiated;
            it.session_tag = req_session_tag;
            it.other_session_tag = req_other_session_tag;
            it.message_ok = req_message_ok;
            it.last_timer = req_last_timer;
            track_item(it);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_rsp.size() == 0) begin
               flag_mismatch("result transfer with nothing expected");
            end else begin
               want = owed_rsp.pop_front();
               if (rsp_result_kind !== want.result_kind) flag_mismatch("result_kind");
               if (rsp_flag !== want.flag) flag_mismatch("flag");
               if (rsp_frame_valid !== want.frame_valid) flag_mismatch("frame_valid");
               if (rsp_frame_timer_tag !== want.frame_timer_tag) flag_mismatch("frame_timer_tag");
               if (rsp_frame_revision !== want.frame_revision) flag_mismatch("frame_revision");
               if (rsp_frame_request_tag !== want.frame_request_tag)
                  flag_mismatch("frame_request_tag");
               if (rsp_last !== want.last) flag_mismatch("last");
            end
         end
      end
      owed_count = owed_rsp.size();
   end

endmodule

### dv/dismiss_retry_tracker_top_test.sv
// Testbench top for the dismiss retry tracker: clock, reset, stimulus and verdict.
// Depends on drt_pkg, dismiss_retry_tracker_top and dismiss_retry_tracker_checker.
`timescale 1ns / 1ps
module dismiss_retry_tracker_top_test;
   import drt_pkg::*;

   localparam logic [47:0] M48 = {48{1'b1}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_opcode = '0;
   logic [TAG_W-1:0]     req_timer_tag = '0;
   logic [REV_W-1:0]     req_revision = '0;
   logic                 req_timer_expired = 1'b0;
   logic [TIME_W-1:0]    req_due_ms = '0;
   logic [TIME_W-1:0]    req_time_now = '0;
   logic [TAG_W-1:0]     req_request_tag = '0;
   logic                 req_negotiated = 1'b0;
   logic [TAG_W-1:0]     req_session_tag = '0;
   logic [TAG_W-1:0]     req_other_session_tag = '0;
   logic                 req_message_ok = 1'b0;
   logic                 req_last_timer = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_result_kind;
   logic                 rsp_flag;
   logic                 rsp_frame_valid;
   logic [TAG_W-1:0]     rsp_frame_timer_tag;
   logic [REV_W-1:0]     rsp_frame_revision;
   logic [TAG_W-1:0]     rsp_frame_request_tag;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;
   int                   err_count;
   int                   owed_count;

   int idle_pct = 0;
   int stall_pct = 0;
   logic [47:0] us_clock = 48'd1000;

   dismiss_retry_tracker_top u_top (.*);
   dismiss_retry_tracker_checker u_chk (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) rsp_stall <= !reset && ($urandom_range(99) < stall_pct);

   initial begin
      #4000000;
      $display("dismiss_retry_tracker_top_test: errors");
      $finish;
   end

   task automatic send_item(item_type it);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.op;
      req_timer_tag <= it.timer_tag;
      req_revision <= it.revision;
      req_timer_expired <= it.timer_expired;
      req_due_ms <= it.due_ms;
      req_time_now <= it.time_now;
      req_request_tag <= it.request_tag;
      req_negotiated <= it.negotiated;
      req_session_tag <= it.session_tag;
      req_other_session_tag <= it.other_session_tag;
      req_message_ok <= it.message_ok;
      req_last_timer <= it.last_timer;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic item_type good_item(op_type op);
      item_type it;
      it = '0;
      it.op = op;
      it.timer_tag = $urandom_range(1, 6);
      it.revision = 48'($urandom_range(1, 4));
      it.request_tag = $urandom_range(1, 4);
      it.timer_expired = 1'($urandom_range(1));
      it.due_ms = 48'($urandom_range(0, 300));
      it.time_now = $urandom_range(9) == 0 ? 48'd0 : 48'($urandom_range(0, 300));
      it.negotiated = $urandom_range(9) != 0;
      it.session_tag = $urandom_range(14) == 0 ? 32'd0 : 32'd1;
      it.other_session_tag = $urandom_range(9) == 0 ? 32'd2 : it.session_tag;
      it.message_ok = $urandom_range(9) != 0;
      it.last_timer = $urandom_range(4) == 0;
      if ($urandom_range(19) == 0) it.request_tag = 0;
      return it;
   endfunction

   function automatic item_type noise_item();
      logic [287:0] v;
      for (int k = 0; k < 9; k++) v[k*32 +: 32] = $urandom;
      return item_type'(v[$bits(item_type)-1:0]);
   endfunction

   task automatic random_items(int count);
      item_type it;
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 10) it = noise_item();
         else if (roll < 45) it = good_item(OP_DISMISS);
         else if (roll < 70) it = good_item(OP_SERVICE);
         else if (roll < 85) it = good_item(OP_ACK);
         else it = good_item(OP_FILTER);
         if (roll >= 10 && it.op == OP_SERVICE) begin
            us_clock = $urandom_range(9) == 0 ? us_clock - 48'($urandom_range(0, 500))
                                              : us_clock + 48'($urandom_range(0, 200));
            it.time_now = us_clock;
         end
         send_item(it);
         if (n == count / 2 && $urandom_range(1)) drain_all();
      end
   endtask

   task automatic directed_items();
      item_type it;
      it = good_item(OP_DISMISS);
      it.negotiated = 1; it.session_tag = '1; it.other_session_tag = '1;
      it.timer_tag = '1; it.revision = M48; it.request_tag = '1; it.timer_expired = 1;
      send_item(it);
      send_item(it);
      it.timer_expired = 0; it.time_now = 0; it.due_ms = 0;
      it.timer_tag = 7;
      send_item(it);
      it.time_now = M48; it.due_ms = M48; it.request_tag = 0;
      send_item(it);
      it.request_tag = 9; it.revision = 2;
      send_item(it);
      it.revision = 5;
      send_item(it);
      it.revision = 0;
      send_item(it);
      it = good_item(OP_SERVICE);
      it.negotiated = 0;
      send_item(it);
      it.negotiated = 1; it.session_tag = 5; it.time_now = 0;
      send_item(it);
      it.time_now = M48;
      send_item(it);
      it.time_now = 10;
      send_item(it);
      it = good_item(OP_ACK);
      it.message_ok = 0; it.session_tag = 3; it.other_session_tag = 3;
      send_item(it);
      it.message_ok = 1; it.timer_tag = 0; it.request_tag = 0;
      send_item(it);
      it.timer_tag = 7; it.request_tag = 9;
      send_item(it);
      it.session_tag = 0; it.other_session_tag = 0;
      send_item(it);
      it = good_item(OP_FILTER);
      it.other_session_tag = 0; it.timer_tag = '1; it.last_timer = 1;
      send_item(it);
      it.other_session_tag = 4; it.last_timer = 0; it.revision = 1;
      send_item(it);
      send_item(it);
      it.timer_tag = 7; it.revision = M48;
      send_item(it);
      it.timer_tag = 1; it.last_timer = 1;
      send_item(it);
   endtask

   initial begin
      int pct[4] = '{0, 70, 0, 11};
      int spct[4] = '{0, 0, 70, 11};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_items();
      drain_all();
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = pct[ph];
         stall_pct = spct[ph];
         case (ph)
            0: begin
               write_csr(CSR_ACK_TIMEOUT, 48'd1);
               write_csr(CSR_MAX_SENDS, 48'd15);
               write_csr(CSR_MAX_REV, M48);
            end
            1: begin
               write_csr(CSR_ACK_TIMEOUT, M48);
               write_csr(CSR_MAX_SENDS, 48'd1);
               write_csr(CSR_MAX_REV, 48'd3);
            end
            2: begin
               write_csr(CSR_ACK_TIMEOUT, 48'd120);
               write_csr(CSR_MAX_SENDS, 48'd0);
               write_csr(CSR_MAX_REV, 48'd1);
            end
            default: begin
               write_csr(CSR_ACK_TIMEOUT, 48'd40);
               write_csr(CSR_MAX_SENDS, 48'd3);
               write_csr(CSR_MAX_REV, 48'd2);
            end
         endcase
         random_items(38);
         drain_all();
      end
      if (err_count == 0) begin
         $display("dismiss_retry_tracker_top_test: clean");
      end else begin
         $display("dismiss_retry_tracker_top_test: errors");
      end
      $finish;
   end

endmodule

### dismiss_retry_tracker_top.f
+incdir+src
src/drt_pkg.sv
src/drt_ram.sv
src/drt_seq.sv
src/dismiss_retry_tracker_top.sv
dv/dismiss_retry_tracker_checker.sv
dv/dismiss_retry_tracker_top_test.sv
